[src/swa_pkg.sv]
// Shared types and constants of the sliding-window ARQ sender.
// No dependencies; compiled first.
package swa_pkg;

    localparam int SEQ_W   = 31;  // sequence number width
    localparam int TIME_W  = 32;  // millisecond time width
    localparam int SLOT_W  = 6;   // slot field width
    localparam int WIN_W   = 7;   // active window register width
    localparam int INIT_W  = 16;  // initial timeout register width
    localparam int STEP_W  = 5;   // remainder unit step counter width
    localparam int APB_AW  = 3;   // byte address bits of the register port
    localparam int APB_DW  = 32;

    localparam logic [SEQ_W-1:0]  SEQ_MAX        = 31'h7FFF_FFFF;
    localparam logic [WIN_W-1:0]  WIN_RESET      = 7'd64;
    localparam logic [INIT_W-1:0] INIT_TO_RESET  = 16'd260;

    // register index, taken from paddr[2]
    localparam logic REG_WINDOW  = 1'b0;
    localparam logic REG_TIMEOUT = 1'b1;

    typedef enum logic [1:0] {
        ACT_SEND    = 2'd0,
        ACT_ACK     = 2'd1,
        ACT_TIMEOUT = 2'd2,
        ACT_DONE    = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        KIND_NEW     = 3'd0,
        KIND_RETX    = 3'd1,
        KIND_ACK     = 3'd2,
        KIND_REFUSED = 3'd3,
        KIND_DISCARD = 3'd4,
        KIND_DONE    = 3'd5
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOD,
        ST_WALK,
        ST_SCAN,
        ST_FLUSH,
        ST_EMIT
    } state_t;

endpackage

[src/swa_if.sv]
// Valid/ready channel interfaces for the command and result streams.
// Depends on swa_pkg.
interface swa_cmd_if;
    import swa_pkg::*;

    logic                valid;
    logic                ready;
    logic [1:0]          action;
    logic                is_last;
    logic [SEQ_W-1:0]    ack_seq;
    logic [TIME_W-1:0]   now_ms;

    modport source (output valid, action, is_last, ack_seq, now_ms, input ready);
    modport sink   (input valid, action, is_last, ack_seq, now_ms, output ready);
endinterface

interface swa_res_if;
    import swa_pkg::*;

    logic                valid;
    logic                ready;
    logic [2:0]          kind;
    logic [SEQ_W-1:0]    seq;
    logic [SLOT_W-1:0]   slot;
    logic [SEQ_W-1:0]    base_seq;
    logic [TIME_W-1:0]   timeout_ms;
    logic                finished;
    logic                last;

    modport source (output valid, kind, seq, slot, base_seq, timeout_ms, finished, last,
                    input ready);
    modport sink   (input valid, kind, seq, slot, base_seq, timeout_ms, finished, last,
                    output ready);
endinterface

[src/swa_ram.sv]
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module swa_ram #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        // read data holds while re is low
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[src/swa_mod.sv]
// Restoring remainder unit: sequence number modulo the window size,
// one quotient bit per cycle. Depends on swa_pkg.
module swa_mod (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [swa_pkg::SEQ_W-1:0] dividend,
    input  logic [swa_pkg::WIN_W-1:0] divisor,
    output logic                      done,
    output logic [swa_pkg::SLOT_W-1:0] rem
);
    import swa_pkg::*;

    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SEQ_W - 1);

    logic                busy_reg;
    logic                done_reg;
    logic [STEP_W-1:0]   cnt_reg;
    logic [SEQ_W-1:0]    dvd_reg;
    logic [WIN_W-1:0]    dsr_reg;
    logic [SLOT_W-1:0]   rem_reg;
    logic [WIN_W-1:0]    trial;
    logic [WIN_W-1:0]    trial_sub;

    // remainder stays below the divisor, so it fits the slot width
    assign trial     = {rem_reg, dvd_reg[SEQ_W-1]};
    assign trial_sub = (trial >= dsr_reg) ? (trial - dsr_reg) : trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == LAST_STEP) && !start;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + STEP_W'(1);
                if (cnt_reg == LAST_STEP)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dsr_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[SEQ_W-2:0], 1'b0};
            rem_reg <= trial_sub[SLOT_W-1:0];
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

[src/sliding_window_arq_sender.sv]
// Top level of the sliding-window ARQ sender: sequencer, register port, output stage.
// Depends on swa_pkg, swa_if, swa_ram and swa_mod.
//
// Sender side of a go-back-N style window. One command is worked at a time and
// a result waits in an output register, so the next command is taken while it
// is still unread. Slot numbers are sequence numbers modulo the active window,
// formed by a shared one-bit-per-cycle remainder unit (31 steps). A send and
// a discarded ack run the remainder unit only, an ack or timeout then also
// walks the window slots (up to WINDOW), a completion skips both; each may wait
// for the result side. Per-slot acked mark and send time live in one RAM of
// WINDOW entries that the ack walk reads and writes back and the timeout scan
// reads; it is not cleared, so no startup pass is needed. Registers: active_window
// at byte 0, initial_timeout_ms at byte 4; writing the latter also reloads the
// timeout estimate. Write registers only while the block is idle.
module sliding_window_arq_sender #(
    parameter int WINDOW = 64
) (
    input  logic                       clk,
    input  logic                       rst_n,
    swa_cmd_if.sink                    cmd,
    swa_res_if.source                  res,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [swa_pkg::APB_AW-1:0] paddr,
    input  logic [swa_pkg::APB_DW-1:0] pwdata,
    output logic [swa_pkg::APB_DW-1:0] prdata,
    output logic                       pready
);
    import swa_pkg::*;

    localparam int              SLOT_AW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int              ENT_W   = TIME_W + 1;
    localparam logic [WIN_W-1:0] WIN_MAX = WIN_W'(WINDOW);

    state_t              state_reg;
    state_t              state_next;

    logic [WIN_W-1:0]    aw_reg;
    logic [INIT_W-1:0]   init_reg;
    logic [TIME_W-1:0]   est_reg;
    logic [SEQ_W-1:0]    base_reg;
    logic [SEQ_W-1:0]    next_reg;
    logic                fin_reg;

    action_t             act_reg;
    logic                last_in_reg;
    logic [SEQ_W-1:0]    ack_reg;
    logic [TIME_W-1:0]   now_reg;
    logic                ack_ok_reg;

    logic [SLOT_W-1:0]   slot_reg;
    logic [SEQ_W-1:0]    walk_reg;
    kind_t               res_kind_reg;
    logic [SEQ_W-1:0]    res_seq_reg;
    logic                cand_valid_reg;
    logic [SEQ_W-1:0]    cand_seq_reg;
    logic [SLOT_W-1:0]   cand_slot_reg;

    logic                ovalid_reg;
    logic [2:0]          okind_reg;
    logic [SEQ_W-1:0]    oseq_reg;
    logic [SLOT_W-1:0]   oslot_reg;
    logic [SEQ_W-1:0]    obase_reg;
    logic [TIME_W-1:0]   oest_reg;
    logic                ofin_reg;
    logic                olast_reg;

    logic [WIN_W-1:0]    w_eff;
    logic                cmd_fire;
    logic                cfg_wr;
    logic                acc_ok;
    logic                refuse;
    logic                out_free;
    logic [SLOT_W-1:0]   slot_inc;
    logic                unacked;
    logic                scan_last;
    logic                walk_end;
    logic                stall;
    logic [TIME_W:0]     est_sum;

    logic                mod_start;
    logic [SEQ_W-1:0]    mod_dvd;
    logic                mod_done;
    logic [SLOT_W-1:0]   mod_rem;

    logic                ram_we;
    logic [SLOT_AW-1:0]  ram_waddr;
    logic [ENT_W-1:0]    ram_wdata;
    logic                ram_re;
    logic [SLOT_AW-1:0]  ram_raddr;
    logic [ENT_W-1:0]    ram_rdata;

    logic                push;
    kind_t               push_kind;
    logic [SEQ_W-1:0]    push_seq;
    logic [SLOT_W-1:0]   push_slot;
    logic                push_last;

    // ---------------------------------------------------------------- helpers
    always_comb
    begin
        if (aw_reg == '0)
        begin
            w_eff = WIN_W'(1);
        end
        else if (aw_reg > WIN_MAX)
        begin
            w_eff = WIN_MAX;
        end
        else
        begin
            w_eff = aw_reg;
        end
    end

    assign cmd_fire  = cmd.valid && cmd.ready;
    assign cfg_wr    = psel && penable && pwrite && pready;
    assign acc_ok    = (cmd.ack_seq >= base_reg) && (cmd.ack_seq < next_reg);
    assign refuse    = fin_reg || (next_reg == SEQ_MAX) ||
                       ({1'b0, next_reg} >= ({1'b0, base_reg} + {25'd0, w_eff}));
    assign out_free  = !ovalid_reg || res.ready;
    assign slot_inc  = (({1'b0, slot_reg} + WIN_W'(1)) == w_eff) ? '0
                                                                  : slot_reg + SLOT_W'(1);
    assign unacked   = !ram_rdata[TIME_W];
    assign scan_last = (walk_reg + SEQ_W'(1)) == next_reg;
    assign walk_end  = walk_reg == ack_reg;
    assign stall     = unacked && cand_valid_reg && !out_free;
    assign est_sum   = {1'b0, est_reg} + {1'b0, now_reg - ram_rdata[TIME_W-1:0]};

    // ---------------------------------------------------------------- units
    swa_mod u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mod_start),
        .dividend (mod_dvd),
        .divisor  (w_eff),
        .done     (mod_done),
        .rem      (mod_rem)
    );

    swa_ram #(
        .WIDTH (ENT_W),
        .DEPTH (WINDOW),
        .AW    (SLOT_AW)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // ---------------------------------------------------------------- next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_fire)
                begin
                    case (action_t'(cmd.action))
                        ACT_SEND:    state_next = ST_MOD;
                        ACT_ACK:     state_next = ST_MOD;
                        ACT_TIMEOUT: state_next = (base_reg != next_reg) ? ST_MOD : ST_IDLE;
                        default:     state_next = ST_EMIT;
                    endcase
                end
            end
            ST_MOD:
            begin
                if (mod_done)
                begin
                    case (act_reg)
                        ACT_ACK:     state_next = ack_ok_reg ? ST_WALK : ST_EMIT;
                        ACT_TIMEOUT: state_next = ST_SCAN;
                        default:     state_next = ST_EMIT;
                    endcase
                end
            end
            ST_WALK:
            begin
                if (walk_end)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_SCAN:
            begin
                if (!stall && scan_last)
                begin
                    state_next = (cand_valid_reg || unacked) ? ST_FLUSH : ST_IDLE;
                end
            end
            ST_FLUSH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------- controls
    always_comb
    begin
        mod_start = 1'b0;
        mod_dvd   = base_reg;
        ram_we    = 1'b0;
        ram_waddr = slot_reg[SLOT_AW-1:0];
        ram_wdata = {1'b1, ram_rdata[TIME_W-1:0]};
        ram_re    = 1'b0;
        ram_raddr = slot_inc[SLOT_AW-1:0];
        push      = 1'b0;
        push_kind = KIND_RETX;
        push_seq  = cand_seq_reg;
        push_slot = cand_slot_reg;
        push_last = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_fire)
                begin
                    case (action_t'(cmd.action))
                        ACT_SEND:
                        begin
                            mod_start = 1'b1;
                            mod_dvd   = next_reg;
                        end
                        ACT_ACK:
                        begin
                            mod_start = 1'b1;
                            mod_dvd   = acc_ok ? base_reg : cmd.ack_seq;
                        end
                        ACT_TIMEOUT:
                        begin
                            mod_start = base_reg != next_reg;
                        end
                        default:
                        begin
                            mod_start = 1'b0;
                        end
                    endcase
                end
            end
            ST_MOD:
            begin
                ram_waddr = mod_rem[SLOT_AW-1:0];
                ram_raddr = mod_rem[SLOT_AW-1:0];
                ram_wdata = {1'b0, now_reg};
                if (mod_done)
                begin
                    ram_we = (act_reg == ACT_SEND) && !refuse;
                    ram_re = ((act_reg == ACT_ACK) && ack_ok_reg) || (act_reg == ACT_TIMEOUT);
                end
            end
            ST_WALK:
            begin
                // mark acked; send time is written back unchanged
                ram_we = 1'b1;
                ram_re = !walk_end;
            end
            ST_SCAN:
            begin
                ram_re = !stall && !scan_last;
                push   = unacked && cand_valid_reg && out_free;
            end
            ST_FLUSH:
            begin
                push      = out_free;
                push_last = 1'b1;
            end
            ST_EMIT:
            begin
                push      = out_free;
                push_kind = res_kind_reg;
                push_seq  = res_seq_reg;
                push_slot = slot_reg;
                push_last = 1'b1;
            end
            default:
            begin
                push = 1'b0;
            end
        endcase
    end

    // ---------------------------------------------------------------- control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            aw_reg         <= WIN_RESET;
            init_reg       <= INIT_TO_RESET;
            est_reg        <= {16'd0, INIT_TO_RESET};
            base_reg       <= '0;
            next_reg       <= '0;
            fin_reg        <= 1'b0;
            cand_valid_reg <= 1'b0;
            ovalid_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_wr)
            begin
                if (paddr[2] == REG_WINDOW)
                begin
                    aw_reg <= pwdata[WIN_W-1:0];
                end
                else
                begin
                    init_reg <= pwdata[INIT_W-1:0];
                    est_reg  <= {16'd0, pwdata[INIT_W-1:0]};
                end
            end
            else if (state_reg == ST_WALK)
            begin
                est_reg <= est_sum[TIME_W:1];
            end

            if (cmd_fire && (action_t'(cmd.action) == ACT_DONE))
            begin
                fin_reg <= 1'b1;
            end
            else if ((state_reg == ST_MOD) && mod_done && (act_reg == ACT_SEND) && !refuse)
            begin
                next_reg <= next_reg + SEQ_W'(1);
                if (last_in_reg)
                begin
                    fin_reg <= 1'b1;
                end
            end

            if ((state_reg == ST_WALK) && walk_end)
            begin
                base_reg <= ack_reg + SEQ_W'(1);
            end

            if ((state_reg == ST_MOD) && mod_done)
            begin
                cand_valid_reg <= 1'b0;
            end
            else if ((state_reg == ST_SCAN) && !stall && unacked)
            begin
                cand_valid_reg <= 1'b1;
            end

            if (push)
            begin
                ovalid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------- payload
    always_ff @(posedge clk)
    begin
        if (cmd_fire)
        begin
            act_reg     <= action_t'(cmd.action);
            last_in_reg <= cmd.is_last;
            ack_reg     <= cmd.ack_seq;
            now_reg     <= cmd.now_ms;
            ack_ok_reg  <= acc_ok;
            if (action_t'(cmd.action) == ACT_DONE)
            begin
                res_kind_reg <= KIND_DONE;
                res_seq_reg  <= '0;
                slot_reg     <= '0;
            end
        end

        case (state_reg)
            ST_MOD:
            begin
                if (mod_done)
                begin
                    slot_reg <= mod_rem;
                    walk_reg <= base_reg;
                    if (act_reg == ACT_SEND)
                    begin
                        res_kind_reg <= refuse ? KIND_REFUSED : KIND_NEW;
                        res_seq_reg  <= next_reg;
                    end
                    else
                    begin
                        res_kind_reg <= KIND_DISCARD;
                        res_seq_reg  <= ack_reg;
                    end
                end
            end
            ST_WALK:
            begin
                if (walk_end)
                begin
                    res_kind_reg <= KIND_ACK;
                    res_seq_reg  <= ack_reg;
                end
                else
                begin
                    walk_reg <= walk_reg + SEQ_W'(1);
                    slot_reg <= slot_inc;
                end
            end
            ST_SCAN:
            begin
                if (!stall)
                begin
                    // hold the newest unacked slot so the final one can carry last
                    if (unacked)
                    begin
                        cand_seq_reg  <= walk_reg;
                        cand_slot_reg <= slot_reg;
                    end
                    if (!scan_last)
                    begin
                        walk_reg <= walk_reg + SEQ_W'(1);
                        slot_reg <= slot_inc;
                    end
                end
            end
            default:
            begin
                walk_reg <= walk_reg;
            end
        endcase

        if (push)
        begin
            okind_reg <= push_kind;
            oseq_reg  <= push_seq;
            oslot_reg <= push_slot;
            obase_reg <= base_reg;
            oest_reg  <= est_reg;
            ofin_reg  <= fin_reg;
            olast_reg <= push_last;
        end
    end

    // ---------------------------------------------------------------- ports
    assign cmd.ready      = state_reg == ST_IDLE;
    assign res.valid      = ovalid_reg;
    assign res.kind       = okind_reg;
    assign res.seq        = oseq_reg;
    assign res.slot       = oslot_reg;
    assign res.base_seq   = obase_reg;
    assign res.timeout_ms = oest_reg;
    assign res.finished   = ofin_reg;
    assign res.last       = olast_reg;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_WINDOW) ? {25'd0, aw_reg} : {16'd0, init_reg};

endmodule

[src/swa_chk.sv]
// Port-level checker for the sliding-window ARQ sender, bound to the top level.
// Depends on swa_pkg and sliding_window_arq_sender.
module swa_chk (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cmd_valid,
    input  logic                       cmd_ready,
    input  logic [1:0]                 cmd_action,
    input  logic                       res_valid,
    input  logic                       res_ready,
    input  logic [2:0]                 res_kind,
    input  logic [swa_pkg::SEQ_W-1:0]  res_seq,
    input  logic [swa_pkg::SEQ_W-1:0]  res_base_seq,
    input  logic                       res_finished
);
    import swa_pkg::*;

    // a held result keeps its kind and sequence number until the transfer
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_kind) && $stable(res_seq))
        else $error("result changed while stalled");

    // every command except timeout produces a result, so intake must close
    a_busy_after_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready && (cmd_action != ACT_TIMEOUT) |=> !cmd_ready)
        else $error("command intake stayed open");

    // a taken ack moves the window base just past it
    a_ack_base: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res_kind == KIND_ACK) |-> res_base_seq == res_seq + 31'd1)
        else $error("window base not advanced past the ack");

    // sent packets never lie below the window base
    a_seq_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && ((res_kind == KIND_NEW) || (res_kind == KIND_RETX))
        |-> res_seq >= res_base_seq)
        else $error("packet below the window base");

    a_done_flag: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res_kind == KIND_DONE) |-> res_finished)
        else $error("completion without finished flag");

endmodule

bind sliding_window_arq_sender swa_chk u_swa_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd_valid    (cmd.valid),
    .cmd_ready    (cmd.ready),
    .cmd_action   (cmd.action),
    .res_valid    (res.valid),
    .res_ready    (res.ready),
    .res_kind     (res.kind),
    .res_seq      (res.seq),
    .res_base_seq (res.base_seq),
    .res_finished (res.finished)
);
